### rtl/etr_pkg.sv
// Package for the event trace ring: sizes, action codes and the
// command and status structs between controller and datapath.
// No dependencies; every other file of the block but etr_ram imports it.
package etr_pkg;

  // Ring geometry.
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);

  // Field widths.
  localparam int TW     = 48;   // timestamp and age
  localparam int IW     = 16;   // event id
  localparam int GW     = 32;   // argument word
  localparam int CW     = 16;   // freeze countdown
  localparam int KW     = 17;   // known-id count
  localparam int ACTW   = 2;    // action code
  localparam int SLOT_W = TW + IW + GW;

  // Action codes; the remaining code does nothing.
  localparam logic [ACTW-1:0] ACT_LOG    = 2'd0;
  localparam logic [ACTW-1:0] ACT_FREEZE = 2'd1;
  localparam logic [ACTW-1:0] ACT_DUMP   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic log_event;   // store an event, subject to the freeze countdown
    logic load_freeze; // load the countdown
    logic rd_first;    // read the newest slot
    logic rd_next;     // read the slot below the last one read
    logic load_entry;  // load an entry word into the output register
    logic load_end;    // load the end word and clear the countdown
  } etr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_used;   // the slot just read is written since reset and holds a non-zero id
    logic out_free;    // the output register can take a word this cycle
  } etr_sts_t;

endpackage

### rtl/etr_if.sv
// Channel interfaces of the event trace ring: input, result and
// configuration write channels with valid/ready handshakes.
// Depends on etr_pkg for the field widths.
interface etr_in_if import etr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ACTW-1:0] action;
  logic [TW-1:0]   time_now;
  logic [IW-1:0]   event_id;
  logic [GW-1:0]   event_arg;
  logic [CW-1:0]   freeze_count;

  modport source (output valid, action, time_now, event_id, event_arg, freeze_count,
                  input ready);
  modport sink   (input valid, action, time_now, event_id, event_arg, freeze_count,
                  output ready);
endinterface

interface etr_out_if import etr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [TW-1:0] entry_age;
  logic [IW-1:0] entry_id;
  logic [GW-1:0] entry_arg;
  logic          id_known;
  logic          is_end;
  logic          last;

  modport source (output valid, entry_age, entry_id, entry_arg, id_known, is_end, last,
                  input ready);
  modport sink   (input valid, entry_age, entry_id, entry_arg, id_known, is_end, last,
                  output ready);
endinterface

interface etr_cfg_if import etr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [KW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/etr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module etr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### rtl/etr_ctrl.sv
// Controller of the event trace ring: decodes accepted words and sequences
// the dump walk. Depends on etr_pkg for codes and the command/status structs.
module etr_ctrl import etr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [ACTW-1:0] in_action,
  output logic            in_ready,
  input  etr_sts_t        sts,
  output etr_cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CHK  = 3'b010,
    ST_FIN  = 3'b100
  } etr_state_t;

  etr_state_t    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;   // reads still to issue in the walk
  logic          in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Next-state and command logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_LOG) begin
            cmd.log_event = 1'b1;
          end else if (in_action == ACT_FREEZE) begin
            cmd.load_freeze = 1'b1;
          end else if (in_action == ACT_DUMP) begin
            // The first read goes out now; DEPTH-2 more follow.
            cmd.rd_first = 1'b1;
            cnt_nxt      = AW'(DEPTH - 2);
            state_nxt    = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // An empty slot is skipped; a used one waits for the output register.
        if (!sts.slot_used || sts.out_free) begin
          cmd.load_entry = sts.slot_used;
          if (cnt_r != '0) begin
            cmd.rd_next = 1'b1;
            cnt_nxt     = cnt_r - AW'(1);
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/etr_dp.sv
// Datapath of the event trace ring: slot memory, id valid bits, pointers,
// freeze countdown, known-id register and the output register.
// Depends on etr_pkg, etr_ram and the etr_out_if interface.
module etr_dp import etr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  etr_cmd_t      cmd,
  output etr_sts_t      sts,
  input  logic [TW-1:0] in_time_now,
  input  logic [IW-1:0] in_event_id,
  input  logic [GW-1:0] in_event_arg,
  input  logic [CW-1:0] in_freeze_count,
  input  logic          cfg_we,
  input  logic [KW-1:0] cfg_data,
  etr_out_if.source     out_ch
);

  logic [AW-1:0]     wp_r, wp_nxt;
  logic [CW-1:0]     cd_r;
  logic [KW-1:0]     kic_r;
  logic [DEPTH-1:0]  vld_r;
  logic [AW-1:0]     rd_addr_r;
  logic [AW-1:0]     rd_addr;
  logic [TW-1:0]     dump_time_r;
  logic              rvld_r;
  logic              wr_en;
  logic              rd_en;
  logic [SLOT_W-1:0] rdata;
  logic [TW-1:0]     r_time;
  logic [IW-1:0]     r_id;
  logic [GW-1:0]     r_arg;

  logic              out_valid_r;
  logic [TW-1:0]     out_age_r;
  logic [IW-1:0]     out_id_r;
  logic [GW-1:0]     out_arg_r;
  logic              out_known_r;
  logic              out_end_r;

  // A log word is dropped while the countdown sits at one.
  assign wr_en  = cmd.log_event && (cd_r != CW'(1));
  assign wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  // Walk address: the newest slot first, then downwards with wrap.
  always_comb begin
    if (cmd.rd_first) begin
      rd_addr = (wp_r == '0) ? AW'(DEPTH - 1) : wp_r - AW'(1);
    end else begin
      rd_addr = (rd_addr_r == '0) ? AW'(DEPTH - 1) : rd_addr_r - AW'(1);
    end
  end
  assign rd_en = cmd.rd_first || cmd.rd_next;

  etr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wp_r),
    .wdata   ({in_time_now, in_event_id, in_event_arg}),
    .re      (rd_en),
    .raddr   (rd_addr),
    .rdata_r (rdata)
  );

  assign r_time = rdata[SLOT_W-1 -: TW];
  assign r_id   = rdata[GW +: IW];
  assign r_arg  = rdata[GW-1:0];

  // A slot not written since reset is empty by its valid bit; id zero also marks it empty.
  assign sts.slot_used = rvld_r && (r_id != '0);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  // Control state: pointer, countdown, known-id count and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cd_r  <= '0;
      kic_r <= '0;
      vld_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r        <= wp_nxt;
        vld_r[wp_r] <= 1'b1;
      end
      if (cmd.load_freeze) begin
        cd_r <= in_freeze_count;
      end else if (cmd.load_end) begin
        cd_r <= '0;
      end else if (cmd.log_event && (cd_r > CW'(1))) begin
        cd_r <= cd_r - CW'(1);
      end
      if (cfg_we) begin
        kic_r <= cfg_data;
      end
    end
  end

  // Walk registers: address, valid bit of the slot read and dump time.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= rd_addr;
      rvld_r    <= vld_r[rd_addr];
    end
    if (cmd.rd_first) begin
      dump_time_r <= in_time_now;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_entry || cmd.load_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      out_age_r   <= dump_time_r - r_time;
      out_id_r    <= r_id;
      out_arg_r   <= r_arg;
      out_known_r <= ({1'b0, r_id} < kic_r);
      out_end_r   <= 1'b0;
    end else if (cmd.load_end) begin
      out_age_r   <= '0;
      out_id_r    <= '0;
      out_arg_r   <= '0;
      out_known_r <= 1'b0;
      out_end_r   <= 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.entry_age = out_age_r;
  assign out_ch.entry_id  = out_id_r;
  assign out_ch.entry_arg = out_arg_r;
  assign out_ch.id_known  = out_known_r;
  assign out_ch.is_end    = out_end_r;
  assign out_ch.last      = out_end_r;

endmodule

### rtl/event_trace_ring_with_freeze.sv
// Top level of the event trace ring with freeze countdown.
// Depends on etr_pkg, the channel interfaces, etr_ctrl, etr_dp and etr_ram.
//
// Usage:
//   in_ch takes one word per action: log an event, load the freeze
//   countdown, or dump the ring. cfg_ch writes the known-id count and is
//   always ready; write it only while the block is idle. out_ch carries
//   the dump: one word per occupied slot but the one at the write
//   pointer, newest first, then an end word with is_end and last set.
//   Log and freeze words never hold in_ch.ready low, so an event can be
//   logged in every cycle outside a dump. A dump holds in_ch.ready low
//   from its acceptance until the end word is loaded into the output
//   register: the walk reads one slot per cycle through the registered
//   slot memory while the receiver takes the waiting words. While the
//   receiver stalls the walk pauses at the slot it holds; nothing is lost.
//   Reset (rst_n low, synchronous) empties every slot through per-slot
//   valid bits, zeroes the write pointer, the countdown and the known-id
//   count; no clearing pass is needed.
module event_trace_ring_with_freeze import etr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  etr_in_if.sink     in_ch,
  etr_out_if.source  out_ch,
  etr_cfg_if.sink    cfg_ch
);

  etr_cmd_t cmd;
  etr_sts_t sts;
  logic     in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  etr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_time_now     (in_ch.time_now),
    .in_event_id     (in_ch.event_id),
    .in_event_arg    (in_ch.event_arg),
    .in_freeze_count (in_ch.freeze_count),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_ch          (out_ch)
  );

  // An accepted dump blocks the input channel in the following cycle.
  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.action == ACT_DUMP)) |=> !in_ch.ready)
    else $error("input still ready after a dump was accepted");

  // Entry words of a dump never show an empty slot.
  a_entry_nonzero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_end) |-> (out_ch.entry_id != '0))
    else $error("dump emitted an empty slot");

  // The end word is the last word and carries zero entry fields.
  a_end_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_end) |->
      (out_ch.last && (out_ch.entry_id == '0) && !out_ch.id_known))
    else $error("malformed end word");

  // Only the end word of a dump raises last.
  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> out_ch.is_end)
    else $error("last raised on an entry word");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the event trace ring with freeze countdown.
// Depends on etr_pkg, the etr_*_if channel interfaces and the top level
// event_trace_ring_with_freeze; it predicts every dump word and compares.
`timescale 1ns / 100ps

module tb_top;
  import etr_pkg::*;

  // Action code that the block ignores.
  localparam logic [ACTW-1:0] ACT_SPARE = 2'd3;
  // Items left in the schedule once idling stops.
  localparam int CALM_TAIL = 30;
  // Idle cycles allowed for the ring to settle after a dump before the next item.
  localparam int SETTLE_CYCLES = DEPTH + 4;

  typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t      kind;
    logic [ACTW-1:0] action;
    logic [TW-1:0]   time_now;
    logic [IW-1:0]   event_id;
    logic [GW-1:0]   event_arg;
    logic [CW-1:0]   freeze_count;
    logic [KW-1:0]   cfg_data;
  } step_t;

  typedef struct {
    logic [TW-1:0] age;
    logic [IW-1:0] id;
    logic [GW-1:0] arg;
    logic          known;
    logic          is_end;
    logic          last;
  } dump_word_t;

  logic clk;
  logic rst_n;

  etr_in_if  in_ch();
  etr_out_if out_ch();
  etr_cfg_if cfg_ch();

  event_trace_ring_with_freeze dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Schedule of words, register writes and drain points.
  step_t      schedule[$];
  // Dump words still to arrive, oldest first.
  dump_word_t dump_expect[$];

  // Shadow copy of the ring and its registers.
  logic [TW-1:0] ring_time[DEPTH];
  logic [IW-1:0] ring_id[DEPTH];
  logic [GW-1:0] ring_arg[DEPTH];
  int            ring_wp = 0;
  logic [CW-1:0] ring_freeze = '0;
  logic [KW-1:0] known_limit = '0;

  int            fail_count = 0;
  bit            stim_done = 1'b0;
  logic [TW-1:0] clock_now = '0;

  int gap_left;
  int settle_left;
  bit draining;
  int stall_left;

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one accepted word to the shadow ring and queues the dump it causes.
  function automatic void ring_apply(input step_t s);
    int         n;
    dump_word_t w;
    case (s.action)
      ACT_LOG: begin
        if (ring_freeze != 16'd1) begin
          if (ring_freeze > 16'd1) ring_freeze = ring_freeze - 16'd1;
          ring_time[ring_wp] = s.time_now;
          ring_id[ring_wp]   = s.event_id;
          ring_arg[ring_wp]  = s.event_arg;
          ring_wp = (ring_wp + 1) % DEPTH;
        end
      end
      ACT_FREEZE: ring_freeze = s.freeze_count;
      ACT_DUMP: begin
        // Newest first, stopping short of the slot at the write pointer.
        n = (ring_wp + DEPTH - 1) % DEPTH;
        while (n != ring_wp) begin
          if (ring_id[n] != '0) begin
            w.age    = s.time_now - ring_time[n];
            w.id     = ring_id[n];
            w.arg    = ring_arg[n];
            w.known  = ({1'b0, ring_id[n]} < known_limit);
            w.is_end = 1'b0;
            w.last   = 1'b0;
            dump_expect.push_back(w);
          end
          n = (n + DEPTH - 1) % DEPTH;
        end
        w.age    = '0;
        w.id     = '0;
        w.arg    = '0;
        w.known  = 1'b0;
        w.is_end = 1'b1;
        w.last   = 1'b1;
        dump_expect.push_back(w);
        ring_freeze = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [TW-1:0] next_stamp();
    if ($urandom_range(0, 6) == 0) clock_now = TW'({$urandom, $urandom});
    else clock_now = clock_now + TW'($urandom_range(0, 2000));
    return clock_now;
  endfunction

  function automatic void push_word(input logic [ACTW-1:0] action, input logic [TW-1:0] stamp,
                                    input logic [IW-1:0] id, input logic [GW-1:0] arg,
                                    input logic [CW-1:0] fc);
    step_t s;
    s.kind         = STEP_WORD;
    s.action       = action;
    s.time_now     = stamp;
    s.event_id     = id;
    s.event_arg    = arg;
    s.freeze_count = fc;
    s.cfg_data     = '0;
    schedule.push_back(s);
  endfunction

  function automatic void push_cfg(input logic [KW-1:0] value);
    step_t s;
    s.kind         = STEP_CFG;
    s.action       = ACT_LOG;
    s.time_now     = '0;
    s.event_id     = '0;
    s.event_arg    = '0;
    s.freeze_count = '0;
    s.cfg_data     = value;
    schedule.push_back(s);
  endfunction

  function automatic void push_drain();
    step_t s;
    s.kind         = STEP_DRAIN;
    s.action       = ACT_LOG;
    s.time_now     = '0;
    s.event_id     = '0;
    s.event_arg    = '0;
    s.freeze_count = '0;
    s.cfg_data     = '0;
    schedule.push_back(s);
  endfunction

  // Shadow ring starts empty, as the block does after reset.
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_time[i] = '0;
      ring_id[i]   = '0;
      ring_arg[i]  = '0;
    end
  end

  // Schedule, reset and the end of the run.
  initial begin
    logic [KW-1:0] limits[6];
    int            counted;
    int            pick;
    logic [IW-1:0] id;

    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_LOG;
    in_ch.time_now     = '0;
    in_ch.event_id     = '0;
    in_ch.event_arg    = '0;
    in_ch.freeze_count = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;

    // Directed part: empty ring, field extremes, age wrap, freeze behaviour.
    push_cfg(17'h10000);
    push_word(ACT_DUMP, 48'd100, '0, '0, '0);
    push_word(ACT_LOG, '0, '0, 32'hAAAA_5555, '0);
    push_word(ACT_LOG, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(ACT_LOG, 48'd5, 16'd1, '0, '0);
    push_word(ACT_SPARE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(ACT_DUMP, '0, '0, '0, '0);
    push_word(ACT_FREEZE, 48'd10, '0, '0, 16'd3);
    push_word(ACT_LOG, 48'd11, 16'h0011, 32'h1111_0000, '0);
    push_word(ACT_LOG, 48'd12, 16'h0012, 32'h2222_0000, '0);
    push_word(ACT_LOG, 48'd13, 16'h0013, 32'h3333_0000, '0);
    push_word(ACT_LOG, 48'd14, 16'h0014, 32'h4444_0000, '0);
    push_word(ACT_DUMP, 48'd20, '0, '0, '0);
    push_word(ACT_LOG, 48'd21, 16'h0021, 32'h5555_0000, '0);
    push_word(ACT_FREEZE, 48'd22, '0, '0, 16'd1);
    push_word(ACT_LOG, 48'd23, 16'h0023, 32'h6666_0000, '0);
    push_word(ACT_FREEZE, 48'd24, '0, '0, 16'd0);
    push_word(ACT_LOG, 48'd25, 16'h0025, 32'h7777_0000, '0);
    push_word(ACT_FREEZE, 48'd26, '0, '0, 16'hFFFF);
    push_word(ACT_LOG, 48'd27, 16'h0027, 32'h8888_0000, '0);
    push_word(ACT_DUMP, 48'd30, '0, '0, '0);
    push_drain();
    push_cfg(17'd0);
    push_word(ACT_DUMP, 48'd40, '0, '0, '0);
    push_drain();
    push_cfg(17'd1);
    push_word(ACT_DUMP, 48'd50, '0, '0, '0);

    // Random part: phases with different known-id counts.
    clock_now = 48'd1000;
    limits[0] = 17'h00000;
    limits[1] = 17'h10000;
    limits[2] = KW'($urandom_range(0, 65536));
    limits[3] = 17'd1;
    limits[4] = 17'h0FFFF;
    limits[5] = 17'h08000;
    for (int ph = 0; ph < 6; ph++) begin
      push_drain();
      push_cfg(limits[ph]);
      counted = 0;
      while (counted < 37) begin
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          case ($urandom_range(0, 9))
            0:       id = '0;
            1, 2:    id = IW'($urandom_range(1, 4));
            default: id = IW'($urandom);
          endcase
          push_word(ACT_LOG, next_stamp(), id, $urandom, CW'($urandom));
          counted++;
        end else if (pick < 75) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: push_word(ACT_FREEZE, next_stamp(), IW'($urandom), $urandom,
                                     CW'($urandom_range(0, 4)));
            5, 6, 7:       push_word(ACT_FREEZE, next_stamp(), IW'($urandom), $urandom,
                                     CW'($urandom_range(5, 80)));
            default:       push_word(ACT_FREEZE, next_stamp(), IW'($urandom), $urandom,
                                     CW'($urandom));
          endcase
          counted++;
        end else if (pick < 96) begin
          if ($urandom_range(0, 2) == 0) begin
            push_word(ACT_DUMP, next_stamp(), IW'($urandom), $urandom, CW'($urandom));
            counted++;
          end
        end else begin
          push_word(ACT_SPARE, next_stamp(), IW'($urandom), $urandom, CW'($urandom));
        end
      end
      push_word(ACT_DUMP, next_stamp(), IW'($urandom), $urandom, CW'($urandom));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (!(stim_done && dump_expect.size() == 0)) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && dump_expect.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Sender: presents scheduled words and register writes, with idle bursts.
  always @(posedge clk) begin : drive_words
    step_t s;
    logic  keep_word;
    logic  keep_cfg;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      gap_left    = 0;
      settle_left = 0;
      draining    = 1'b0;
    end else begin
      keep_word = in_ch.valid && !in_ch.ready;
      keep_cfg  = cfg_ch.valid && !cfg_ch.ready;
      if (!keep_word && !keep_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (draining) begin
          // Hold off until the last dump word is in, then let the ring settle.
          if (dump_expect.size() != 0) settle_left = SETTLE_CYCLES;
          else if (settle_left != 0) settle_left--;
          else draining = 1'b0;
        end else if (schedule.size() != 0) begin
          s = schedule.pop_front();
          case (s.kind)
            STEP_WORD: begin
              keep_word = 1'b1;
              in_ch.action       <= s.action;
              in_ch.time_now     <= s.time_now;
              in_ch.event_id     <= s.event_id;
              in_ch.event_arg    <= s.event_arg;
              in_ch.freeze_count <= s.freeze_count;
            end
            STEP_CFG: begin
              keep_cfg = 1'b1;
              cfg_ch.data <= s.cfg_data;
            end
            default: begin
              draining    = 1'b1;
              settle_left = SETTLE_CYCLES;
            end
          endcase
          if (schedule.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 16);
        end else begin
          stim_done = 1'b1;
        end
      end
      in_ch.valid  <= keep_word;
      cfg_ch.valid <= keep_cfg;
    end
  end

  // Receiver: stalls the dump channel in random bursts.
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (schedule.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: tracks accepted words and register writes, checks every dump word.
  always @(posedge clk) begin : watch_channels
    step_t      s;
    dump_word_t w;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) known_limit = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        s.kind         = STEP_WORD;
        s.action       = in_ch.action;
        s.time_now     = in_ch.time_now;
        s.event_id     = in_ch.event_id;
        s.event_arg    = in_ch.event_arg;
        s.freeze_count = in_ch.freeze_count;
        s.cfg_data     = '0;
        ring_apply(s);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dump_expect.size() == 0) begin
          $error("dump word with none expected: entry_id %0h", out_ch.entry_id);
          fail_count++;
        end else begin
          w = dump_expect.pop_front();
          check_field("entry_age", 64'(w.age), 64'(out_ch.entry_age));
          check_field("entry_id", 64'(w.id), 64'(out_ch.entry_id));
          check_field("entry_arg", 64'(w.arg), 64'(out_ch.entry_arg));
          check_field("id_known", 64'(w.known), 64'(out_ch.id_known));
          check_field("is_end", 64'(w.is_end), 64'(out_ch.is_end));
          check_field("last", 64'(w.last), 64'(out_ch.last));
        end
      end
    end
  end

endmodule
